### rtl/blid_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bounded list block.
// No dependencies; every rtl file references this package by scoped names.
package blid_pkg;

  localparam int CAPACITY    = 64;          // most entries the list may hold (2..64)
  localparam int STORE_DEPTH = 64;          // ring store slots
  localparam int SLOT_W      = 6;           // slot index width, log2(STORE_DEPTH)
  localparam int COUNT_W     = 7;           // entry count, 0..CAPACITY
  localparam int VALUE_W     = 32;
  localparam int POS_W       = 6;
  localparam int KIND_W      = 2;
  localparam int IN_DATA_W   = 40;          // item_value + position, padded to bytes
  localparam int OUT_USER_W  = 2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [KIND_W-1:0] KIND_FRONT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BACK   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

  typedef enum logic [1:0] {
    OP_FRONT,
    OP_BACK,
    OP_DELETE,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t                        op;
    logic signed [VALUE_W-1:0]  value;
    logic [POS_W-1:0]           position;
  } cmd_t;

endpackage

### rtl/blid_front.sv
`timescale 1ns / 1ps
// Input stage: accepts command transactions and decodes the kind into an operation.
// Depends on blid_pkg.
module blid_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [blid_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic [blid_pkg::KIND_W-1:0]   s_tuser,
  output logic                          cmd_valid,
  input  logic                          cmd_ready,
  output blid_pkg::cmd_t                cmd
);

  blid_pkg::cmd_t decoded;
  logic           hold_vld;

  always_comb begin
    decoded.value    = s_tdata[blid_pkg::VALUE_W-1:0];
    decoded.position = s_tdata[blid_pkg::VALUE_W +: blid_pkg::POS_W];
    case (s_tuser)
      blid_pkg::KIND_FRONT:  decoded.op = blid_pkg::OP_FRONT;
      blid_pkg::KIND_BACK:   decoded.op = blid_pkg::OP_BACK;
      blid_pkg::KIND_DELETE: decoded.op = blid_pkg::OP_DELETE;
      default:               decoded.op = blid_pkg::OP_NONE;
    endcase
  end

  assign s_tready  = !hold_vld || cmd_ready;
  assign cmd_valid = hold_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_vld <= 1'b0;
    end else if (s_tready) begin
      hold_vld <= s_tvalid;
    end
  end

  // Payload register, no reset.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd <= decoded;
    end
  end

endmodule

### rtl/blid_cmd_fifo.sv
`timescale 1ns / 1ps
// Short command queue between the decode stage and the list engine.
// Depends on blid_pkg.
module blid_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  blid_pkg::cmd_t in_cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output blid_pkg::cmd_t out_cmd
);

  blid_pkg::cmd_t                slots [blid_pkg::QUEUE_DEPTH];
  logic [blid_pkg::QPTR_W-1:0]   wr_ptr;
  logic [blid_pkg::QPTR_W-1:0]   rd_ptr;
  logic [blid_pkg::QCNT_W-1:0]   fill;
  logic                          push;
  logic                          pop;

  assign in_ready  = fill != blid_pkg::QCNT_W'(blid_pkg::QUEUE_DEPTH);
  assign out_valid = fill != '0;
  assign out_cmd   = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == blid_pkg::QPTR_W'(blid_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == blid_pkg::QPTR_W'(blid_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_cmd;
    end
  end

endmodule

### rtl/blid_back.sv
`timescale 1ns / 1ps
// List engine: ring store, insert/delete execution and the listing stream.
// Depends on blid_pkg.
module blid_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  output logic                              cmd_ready,
  input  blid_pkg::cmd_t                    cmd,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [blid_pkg::VALUE_W-1:0]      m_tdata,
  output logic                              m_tlast,
  output logic [blid_pkg::OUT_USER_W-1:0]   m_tuser
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_LIST
  } state_t;

  state_t                          state;
  logic [blid_pkg::VALUE_W-1:0]    store [blid_pkg::STORE_DEPTH];
  logic [blid_pkg::VALUE_W-1:0]    rd_data;
  logic [blid_pkg::SLOT_W-1:0]     front_slot;
  logic [blid_pkg::COUNT_W-1:0]    entry_count;
  logic [blid_pkg::COUNT_W-1:0]    idx;
  logic                            dropped;
  logic                            sh_vld;
  logic [blid_pkg::SLOT_W-1:0]     sh_addr;
  logic                            lst_vld;
  logic                            lst_last;

  logic                            take;
  logic                            is_full;
  logic                            o_free;
  logic                            idx_live;
  logic                            sh_issue;
  logic                            lst_move;
  logic                            lst_issue;
  logic                            empty_emit;
  logic                            we;
  logic [blid_pkg::SLOT_W-1:0]     wa;
  logic [blid_pkg::VALUE_W-1:0]    wd;
  logic                            re;
  logic [blid_pkg::SLOT_W-1:0]     ra;

  assign cmd_ready  = state == ST_IDLE;
  assign take       = cmd_valid && cmd_ready;
  assign is_full    = entry_count >= blid_pkg::COUNT_W'(blid_pkg::CAPACITY);
  assign o_free     = !m_tvalid || m_tready;
  assign idx_live   = idx < entry_count;
  assign ra         = front_slot + idx[blid_pkg::SLOT_W-1:0];
  assign sh_issue   = (state == ST_SHIFT) && idx_live;
  assign lst_move   = (state == ST_LIST) && lst_vld && o_free;
  assign lst_issue  = (state == ST_LIST) && idx_live && (!lst_vld || lst_move);
  assign empty_emit = (state == ST_LIST) && (entry_count == '0) && o_free;
  assign re         = sh_issue || lst_issue;

  // Single write port: inserts from idle, moved entries while closing a gap.
  always_comb begin
    we = 1'b0;
    wa = sh_addr;
    wd = rd_data;
    if (take && !is_full && cmd.op == blid_pkg::OP_FRONT) begin
      we = 1'b1;
      wa = front_slot - blid_pkg::SLOT_W'(1);
      wd = cmd.value;
    end else if (take && !is_full && cmd.op == blid_pkg::OP_BACK) begin
      we = 1'b1;
      wa = front_slot + entry_count[blid_pkg::SLOT_W-1:0];
      wd = cmd.value;
    end else if (state == ST_SHIFT && sh_vld) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      store[wa] <= wd;
    end
    if (re) begin
      rd_data <= store[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      front_slot  <= '0;
      entry_count <= '0;
      idx         <= '0;
      dropped     <= 1'b0;
      sh_vld      <= 1'b0;
      lst_vld     <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (take) begin
            dropped <= is_full && (cmd.op == blid_pkg::OP_FRONT || cmd.op == blid_pkg::OP_BACK);
            // An in-range delete closes the gap first; everything else lists at once.
            if (cmd.op == blid_pkg::OP_DELETE &&
                blid_pkg::COUNT_W'(cmd.position) < entry_count) begin
              idx    <= blid_pkg::COUNT_W'(cmd.position) + 1'b1;
              sh_vld <= 1'b0;
              state  <= ST_SHIFT;
            end else begin
              idx   <= '0;
              state <= ST_LIST;
            end
            case (cmd.op)
              blid_pkg::OP_FRONT: begin
                if (!is_full) begin
                  front_slot  <= front_slot - blid_pkg::SLOT_W'(1);
                  entry_count <= entry_count + 1'b1;
                end
              end
              blid_pkg::OP_BACK: begin
                if (!is_full) begin
                  entry_count <= entry_count + 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_SHIFT: begin
          // Read slot k+1 each cycle, write it to slot k the next.
          sh_vld  <= sh_issue;
          sh_addr <= ra - blid_pkg::SLOT_W'(1);
          if (sh_issue) begin
            idx <= idx + 1'b1;
          end else if (!sh_vld) begin
            entry_count <= entry_count - 1'b1;
            idx         <= '0;
            state       <= ST_LIST;
          end
        end
        ST_LIST: begin
          if (lst_issue) begin
            idx      <= idx + 1'b1;
            lst_vld  <= 1'b1;
            lst_last <= (idx + 1'b1) == entry_count;
          end else if (lst_move) begin
            lst_vld <= 1'b0;
          end
          if (entry_count == '0) begin
            if (o_free) begin
              state <= ST_IDLE;
            end
          end else if (!idx_live && (!lst_vld || lst_move)) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // Output register.
      if (lst_move) begin
        m_tvalid <= 1'b1;
        m_tdata  <= rd_data;
        m_tlast  <= lst_last;
        m_tuser  <= {dropped, 1'b0};
      end else if (empty_emit) begin
        m_tvalid <= 1'b1;
        m_tdata  <= '0;
        m_tlast  <= 1'b1;
        m_tuser  <= {dropped, 1'b1};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

### rtl/bounded_list_insert_delete.sv
`timescale 1ns / 1ps
// Top level of the bounded list: decode stage, command queue and list engine.
// Depends on blid_pkg, blid_front, blid_cmd_fifo and blid_back.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tuser: kind; tdata: item_value, position
//  m_*     | out | m_tvalid/m_tready  | tdata: entry_value; tlast: is_last;
//          |     |                    | tuser: list_empty, insert_dropped
//
// A listing streams one entry per cycle, while the receiver does not stall, from the
// ring store's single registered read port. The engine accepts a new command only
// once it has finished the previous listing. A delete first closes the gap, one entry
// per cycle through the same read port. Up to three commands can wait in the decode
// register and queue while a listing streams.
// rst is synchronous, active high, and clears all control state; the store is not
// cleared. Downstream stalls freeze the listing in place; nothing is lost.
module bounded_list_insert_delete (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [31:0] item_value, [37:32] position, [39:38] zero
  input  logic [blid_pkg::IN_DATA_W-1:0]     s_tdata,
  // [1:0] kind
  input  logic [blid_pkg::KIND_W-1:0]        s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [31:0] entry_value
  output logic [blid_pkg::VALUE_W-1:0]       m_tdata,
  output logic                               m_tlast,
  // [0] list_empty, [1] insert_dropped
  output logic [blid_pkg::OUT_USER_W-1:0]    m_tuser
);

  logic           dec_valid;
  logic           dec_ready;
  blid_pkg::cmd_t dec_cmd;
  logic           q_valid;
  logic           q_ready;
  blid_pkg::cmd_t q_cmd;

  // Accept and decode incoming transactions.
  blid_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd_valid (dec_valid),
    .cmd_ready (dec_ready),
    .cmd       (dec_cmd)
  );

  // Buffer decoded commands so input and listing stall independently.
  blid_cmd_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .in_cmd    (dec_cmd),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_cmd   (q_cmd)
  );

  // Execute commands on the ring store and stream the list.
  blid_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule

### bench/list_listing_checker.sv
`timescale 1ns / 1ps
// Checker for the bounded list: tracks the list contents from accepted commands,
// predicts each listing and compares it with the output stream, entry by entry.
// Depends on blid_pkg for widths, the command encoding and the list capacity.
module list_listing_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [blid_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic [blid_pkg::KIND_W-1:0]     s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [blid_pkg::VALUE_W-1:0]    m_tdata,
  input  logic                            m_tlast,
  input  logic [blid_pkg::OUT_USER_W-1:0] m_tuser,
  output int                              fail_count,
  output int                              pending
);

  typedef struct packed {
    logic [blid_pkg::VALUE_W-1:0] entry;
    logic                         is_last;
    logic                         is_empty;
    logic                         dropped;
  } listing_beat_t;

  logic [blid_pkg::VALUE_W-1:0] shadow_list[$];
  listing_beat_t                listing_q[$];

  // Update the shadow list for one command and queue the listing it produces.
  task automatic apply_command(input blid_pkg::op_t op,
                               input logic [blid_pkg::VALUE_W-1:0] value,
                               input logic [blid_pkg::POS_W-1:0] pos);
    logic          dropped;
    listing_beat_t beat;
    dropped = 1'b0;
    case (op)
      blid_pkg::OP_FRONT, blid_pkg::OP_BACK: begin
        if (shadow_list.size() >= blid_pkg::CAPACITY) dropped = 1'b1;
        else if (op == blid_pkg::OP_FRONT) shadow_list.push_front(value);
        else shadow_list.push_back(value);
      end
      blid_pkg::OP_DELETE: begin
        if (int'(pos) < shadow_list.size()) shadow_list.delete(int'(pos));
      end
      default: ;
    endcase
    if (shadow_list.size() == 0) begin
      beat.entry = '0;
      beat.is_last = 1'b1;
      beat.is_empty = 1'b1;
      beat.dropped = dropped;
      listing_q.push_back(beat);
    end else begin
      for (int i = 0; i < shadow_list.size(); i++) begin
        beat.entry = shadow_list[i];
        beat.is_last = (i == shadow_list.size() - 1);
        beat.is_empty = 1'b0;
        beat.dropped = dropped;
        listing_q.push_back(beat);
      end
    end
  endtask

  always @(posedge clk) begin
    listing_beat_t got;
    listing_beat_t want;
    if (rst) begin
      shadow_list.delete();
      listing_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.entry = m_tdata;
        got.is_last = m_tlast;
        got.is_empty = m_tuser[0];
        got.dropped = m_tuser[1];
        if (listing_q.size() == 0) begin
          $display("%0t: unexpected entry, expected none, got value %0d last %b empty %b dropped %b",
                   $time, $signed(got.entry), got.is_last, got.is_empty, got.dropped);
          fail_count++;
        end else begin
          want = listing_q.pop_front();
          if (got !== want) begin
            $display("%0t: entry mismatch, expected value %0d last %b empty %b dropped %b",
                     $time, $signed(want.entry), want.is_last, want.is_empty, want.dropped);
            $display("%0t:                    got value %0d last %b empty %b dropped %b",
                     $time, $signed(got.entry), got.is_last, got.is_empty, got.dropped);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready)
        apply_command(blid_pkg::op_t'(s_tuser), s_tdata[blid_pkg::VALUE_W-1:0],
                      s_tdata[blid_pkg::VALUE_W +: blid_pkg::POS_W]);
    end
    pending = listing_q.size();
  end

endmodule

### bench/bounded_list_insert_delete_test.sv
`timescale 1ns / 1ps
// Top of the bounded list bench: clock, reset, command stimulus and the verdict.
// Depends on blid_pkg, bounded_list_insert_delete and list_listing_checker.
module bounded_list_insert_delete_test;

  logic                            clk;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  // [31:0] item_value, [37:32] position, [39:38] zero
  logic [blid_pkg::IN_DATA_W-1:0]  s_tdata;
  // [1:0] kind
  logic [blid_pkg::KIND_W-1:0]     s_tuser;
  logic                            m_tvalid;
  logic                            m_tready;
  // [31:0] entry_value
  logic [blid_pkg::VALUE_W-1:0]    m_tdata;
  logic                            m_tlast;
  // [0] list_empty, [1] insert_dropped
  logic [blid_pkg::OUT_USER_W-1:0] m_tuser;

  int fail_count;
  int pending;
  // Rough occupancy seen from the stimulus side; only steers command choice.
  int fill;
  // Set for the closing stretch: no idling on either side.
  bit calm;

  bounded_list_insert_delete dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  list_listing_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run (every listing full length,
  // every entry stalled the longest burst).
  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver: accept by default, stall in random bursts.
  initial begin : rx_side
    int hold;
    hold = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else begin
        m_tready <= 1'b1;
        if (!rst && !calm && $urandom_range(0, 7) == 0) hold = int'($urandom_range(1, 19));
      end
    end
  end

  // Present one command and hold it until the transaction completes. Return at
  // the following falling edge with tvalid still high, so the caller either
  // presents the next command or drops tvalid with a single assignment.
  task automatic send_cmd(input blid_pkg::op_t op,
                          input logic [blid_pkg::VALUE_W-1:0] value,
                          input logic [blid_pkg::POS_W-1:0] pos);
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {2'b00, pos, value};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    if ((op == blid_pkg::OP_FRONT || op == blid_pkg::OP_BACK) && fill < blid_pkg::CAPACITY)
      fill++;
    else if (op == blid_pkg::OP_DELETE && int'(pos) < fill) fill--;
  endtask

  // Random sender gap, skipped in the closing stretch.
  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
  endtask

  // Hold off new commands until every queued listing has streamed out.
  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // One random command: inserts with the given percentage, mostly in-range
  // deletes otherwise, and a few unused kinds.
  task automatic send_random(input int insert_pct);
    int                           r;
    blid_pkg::op_t                op;
    logic [blid_pkg::POS_W-1:0]   pos;
    r = int'($urandom_range(0, 99));
    if (r < insert_pct)
      op = ($urandom_range(0, 1) != 0) ? blid_pkg::OP_BACK : blid_pkg::OP_FRONT;
    else if (r < 96) op = blid_pkg::OP_DELETE;
    else op = blid_pkg::OP_NONE;
    if (op == blid_pkg::OP_DELETE && fill > 0 && $urandom_range(0, 4) != 0)
      pos = blid_pkg::POS_W'($urandom_range(0, fill - 1));
    else
      pos = blid_pkg::POS_W'($urandom_range(0, 63));
    send_cmd(op, $urandom(), pos);
    maybe_gap();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    fill = 0;
    calm = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty-list deletes and the unused kind, value extremes at both
    // ends, deletes of last, first, middle and past the end, back to empty.
    send_cmd(blid_pkg::OP_DELETE, 32'h0000_0000, 6'd0);  maybe_gap();
    send_cmd(blid_pkg::OP_NONE,   32'hFFFF_FFFF, 6'd63); maybe_gap();
    send_cmd(blid_pkg::OP_FRONT,  32'h7FFF_FFFF, 6'd63); maybe_gap();
    send_cmd(blid_pkg::OP_BACK,   32'h8000_0000, 6'd0);  maybe_gap();
    send_cmd(blid_pkg::OP_FRONT,  32'h0000_0000, 6'd21); maybe_gap();
    send_cmd(blid_pkg::OP_BACK,   32'hFFFF_FFFF, 6'd42); maybe_gap();
    send_cmd(blid_pkg::OP_FRONT,  32'h0000_0001, 6'd0);  maybe_gap();
    send_cmd(blid_pkg::OP_NONE,   32'h5555_5555, 6'd5);  maybe_gap();
    send_cmd(blid_pkg::OP_DELETE, 32'hAAAA_AAAA, 6'd63); maybe_gap();
    send_cmd(blid_pkg::OP_DELETE, 32'h1234_5678, 6'd5);  maybe_gap();
    hold_until_drained();
    send_cmd(blid_pkg::OP_DELETE, 32'h0,         6'd4);  maybe_gap();
    send_cmd(blid_pkg::OP_DELETE, 32'h0,         6'd0);  maybe_gap();
    send_cmd(blid_pkg::OP_DELETE, 32'h0,         6'd1);  maybe_gap();
    send_cmd(blid_pkg::OP_DELETE, 32'h0,         6'd1);  maybe_gap();
    send_cmd(blid_pkg::OP_DELETE, 32'h0,         6'd0);  maybe_gap();
    send_cmd(blid_pkg::OP_DELETE, 32'hFFFF_FFFF, 6'd0);  maybe_gap();

    // Grow to capacity through a mix that keeps the ring wrapping both ways.
    while (fill < blid_pkg::CAPACITY) send_random(90);
    // Push inserts into the full list; each listing must carry the drop flag.
    repeat (4) send_random(100);
    hold_until_drained();

    // Shrink with mostly deletes, then a closing stretch with no idling.
    repeat (8) send_random(30);
    calm = 1'b1;
    repeat (6) send_random(60);

    // Wait out the remaining listings, then idle long enough to catch strays.
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (80) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
